FILE: design/urta_pkg.sv
// Package: shared constants, command/status types and digit helpers for the radix-to-ASCII block.
`timescale 1ns / 1ps

package urta_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	// Long division retires DIV_BITS quotient bits per clock.
	localparam int DIV_BITS    = 8;
	localparam int DIV_CHUNKS  = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
	localparam int WORK_W      = DIV_CHUNKS * DIV_BITS;
	localparam int CHUNK_W     = (DIV_CHUNKS > 1) ? $clog2(DIV_CHUNKS) : 1;

	localparam int RADIX_W     = 5;
	localparam int DIGIT_W     = 4;
	localparam int CHAR_W      = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0] CHAR_ALPHA = CHAR_W'(8'h57); // 'a' - 10

	typedef struct packed {
		logic load;       // latch value and base, clear digit count
		logic div_step;   // one chunk of long division
		logic div_first;  // first chunk of a digit: remainder starts at zero
		logic wr;         // store remainder as next digit
		logic out_load;   // capture next character into output register
	} cmd_t;

	typedef struct packed {
		logic done;       // quotient reached zero or store is full
		logic out_last;   // output register holds the final digit
	} sts_t;

	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN)
			res = RADIX_MIN;
		else if (r > RADIX_MAX)
			res = RADIX_MAX;
		return res;
	endfunction

	function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DIGIT_W'(10))
			c = CHAR_ZERO + CHAR_W'(d);
		else
			c = CHAR_ALPHA + CHAR_W'(d);
		return c;
	endfunction

endpackage

FILE: design/urta_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module urta_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/urta_datapath.sv
// Datapath: chunked long division, digit store, read pointer and output register.
`timescale 1ns / 1ps

module urta_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  urta_pkg::cmd_t                    cmd,
	output urta_pkg::sts_t                    sts,
	input  logic [63:0]                       value,
	input  logic [urta_pkg::RADIX_W-1:0]      radix,
	output logic [urta_pkg::CHAR_W-1:0]       digit_char,
	output logic                              last_digit
);

	logic [urta_pkg::WORK_W-1:0]  work_q;
	logic [urta_pkg::RADIX_W-1:0] base_q;
	logic [urta_pkg::RADIX_W-1:0] rem_q;
	logic [urta_pkg::CNT_W-1:0]   cnt_q;
	logic [urta_pkg::ADDR_W-1:0]  rd_ptr_q;
	logic [urta_pkg::CHAR_W-1:0]  char_q;
	logic                         last_q;

	logic [urta_pkg::WORK_W-1:0]  work_nx;
	logic [urta_pkg::RADIX_W-1:0] rem_nx;
	logic [urta_pkg::DIGIT_W-1:0] rd_digit;

	// Restoring division: dividend bits shift out the top, quotient bits shift in at the bottom.
	always_comb begin
		rem_nx  = cmd.div_first ? '0 : rem_q;
		work_nx = work_q;
		for (int i = 0; i < urta_pkg::DIV_BITS; i++) begin
			rem_nx  = {rem_nx[urta_pkg::RADIX_W-2:0], work_nx[urta_pkg::WORK_W-1]};
			work_nx = {work_nx[urta_pkg::WORK_W-2:0], 1'b0};
			if (rem_nx >= base_q) begin
				rem_nx     = rem_nx - base_q;
				work_nx[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q   <= '0;
			cnt_q    <= '0;
			rd_ptr_q <= '0;
			last_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				work_q <= urta_pkg::WORK_W'(value[urta_pkg::VALUE_WIDTH-1:0]);
				cnt_q  <= '0;
			end else if (cmd.div_step) begin
				work_q <= work_nx;
			end else if (cmd.wr) begin
				cnt_q    <= cnt_q + 1'b1;
				rd_ptr_q <= cnt_q[urta_pkg::ADDR_W-1:0];
			end else if (cmd.out_load) begin
				last_q   <= (rd_ptr_q == '0);
				rd_ptr_q <= rd_ptr_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			base_q <= urta_pkg::clamp_radix(radix);
		if (cmd.div_step)
			rem_q <= rem_nx;
		if (cmd.out_load)
			char_q <= urta_pkg::glyph(rd_digit);
	end

	urta_ram #(
		.WIDTH(urta_pkg::DIGIT_W),
		.DEPTH(urta_pkg::STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr),
		.waddr(cnt_q[urta_pkg::ADDR_W-1:0]),
		.wdata(rem_q[urta_pkg::DIGIT_W-1:0]),
		.raddr(rd_ptr_q),
		.rdata(rd_digit)
	);

	assign sts.done     = (work_q == '0) ||
	                      (cnt_q == urta_pkg::CNT_W'(urta_pkg::STORE_DEPTH - 1));
	assign sts.out_last = last_q;

	assign digit_char = char_q;
	assign last_digit = last_q;

endmodule

FILE: design/urta_ctrl.sv
// Controller: sequences division chunks, digit writes and the output stream.
`timescale 1ns / 1ps

module urta_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output urta_pkg::cmd_t cmd,
	input  urta_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_WR,
		S_RD,
		S_LD,
		S_OUT
	} state_t;

	state_t                       state_q;
	logic [urta_pkg::CHUNK_W-1:0] chunk_q;
	logic                         out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == S_IDLE) && in_valid;
		cmd.div_step  = (state_q == S_DIV);
		cmd.div_first = (state_q == S_DIV) && (chunk_q == '0);
		cmd.wr        = (state_q == S_WR);
		cmd.out_load  = (state_q == S_LD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			chunk_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					chunk_q <= '0;
					if (in_valid)
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (chunk_q == urta_pkg::CHUNK_W'(urta_pkg::DIV_CHUNKS - 1)) begin
						chunk_q <= '0;
						state_q <= S_WR;
					end else begin
						chunk_q <= chunk_q + 1'b1;
					end
				end
				S_WR: begin
					state_q <= sts.done ? S_RD : S_DIV;
				end
				// store read is in flight; data lands in the next cycle
				S_RD: begin
					state_q <= S_LD;
				end
				S_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= sts.out_last ? S_IDLE : S_LD;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: design/unsigned_radix_to_ascii.sv
// Top level: unsigned integer to lower-case ASCII digits in base 2..16.
`timescale 1ns / 1ps

// Converts an unsigned value (low VALUE_WIDTH bits used) to its digits in the
// given base, clamped to 2..16, and sends one ASCII character per output
// transaction, most significant first, with last_digit set on the final one.
// Zero yields a single '0'. One input transaction is handled at a time: in_stall
// stays high from acceptance until the last digit has been taken. Each digit is
// produced by long division that retires 8 quotient bits per clock, in
// DIV_CHUNKS chunk steps, and then written to the digit store. When the
// quotient reaches zero or the store fills, a registered store read starts,
// and each digit in turn is loaded into the output register and held there
// until it has been taken.

module unsigned_radix_to_ascii (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [63:0]                   value,
	input  logic [urta_pkg::RADIX_W-1:0]  radix,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [urta_pkg::CHAR_W-1:0]   digit_char,
	output logic                          last_digit
);

	urta_pkg::cmd_t cmd;
	urta_pkg::sts_t sts;

	urta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	urta_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (value),
		.radix     (radix),
		.digit_char(digit_char),
		.last_digit(last_digit)
	);

endmodule
